/* rtl/core/combined_lcg_shuffle_rng_unit_assert.svh */
// Assertion macros for the combined LCG shuffle generator.
`ifndef COMBINED_LCG_SHUFFLE_RNG_UNIT_ASSERT_SVH
`define COMBINED_LCG_SHUFFLE_RNG_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CLSRNG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("clsrng: invariant violated");
`define CLSRNG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clsrng: implication violated");
`else
`define CLSRNG_ASSERT(label, clk, rst, prop)
`define CLSRNG_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/clsrng_pkg.sv */
package clsrng_pkg;

   localparam int VAL_W  = 31;
   localparam int SEED_W = 32;

   localparam logic [VAL_W-1:0] M1 = 31'd2147483563;
   localparam logic [VAL_W-1:0] M2 = 31'd2147483399;
   localparam logic [15:0]      A1 = 16'd40014;
   localparam logic [15:0]      A2 = 16'd40692;
   localparam logic [7:0]       C1 = 8'd85;
   localparam logic [7:0]       C2 = 8'd249;

   localparam logic [VAL_W-1:0] OUT_MAX = 31'd2147483562;

   typedef enum logic {
      OP_DRAW = 1'b0,
      OP_SEED = 1'b1
   } op_type;

endpackage

/* rtl/core/clsrng_ram.sv */
module clsrng_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/clsrng_mulmod.sv */
module clsrng_mulmod (
   input  logic                           clock,
   input  logic [clsrng_pkg::VAL_W-1:0]   operand,
   input  logic [15:0]                    multiplier,
   input  logic [7:0]                     fold,
   input  logic [clsrng_pkg::VAL_W-1:0]   modulus,
   output logic [clsrng_pkg::VAL_W-1:0]   result
);
   import clsrng_pkg::*;

   logic [46:0]      prod_ff;
   logic [46:0]      prod_in;
   logic [15:0]      hi;
   logic [30:0]      lo;
   logic [23:0]      hi_fold;
   logic [31:0]      total;
   logic [31:0]      reduced;

   assign prod_in = {16'd0, operand} * {31'd0, multiplier};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign hi      = prod_ff[46:31];
   assign lo      = prod_ff[30:0];
   assign hi_fold = {8'd0, hi} * {16'd0, fold};
   assign total   = {8'd0, hi_fold} + {1'b0, lo};
   assign reduced = (total >= {1'b0, modulus}) ? total - {1'b0, modulus} : total;
   assign result  = reduced[VAL_W-1:0];

endmodule

/* rtl/core/combined_lcg_shuffle_rng_unit.sv */
// Combined two-modulus multiplicative generator with a shuffle table,
// raw integer output. A seed beat (operation 1) loads both generators with
// max(seed+1,1), saturated at 2^31-1, and runs TABLE_DEPTH+8 steps of the first
// generator to fill the table, each step being a registered multiply followed
// by a fold-and-reduce, and returns no beat. A draw beat (operation 0) returns
// one beat: advance both generators and compute the table index, read the table
// entry from its registered-read memory, then, once the output register is free,
// combine and write the entry back. One beat is in flight at a time, so a new
// beat is not accepted until the previous one has finished; a finished result
// waits in the output register while the next beat is accepted.
// Draws issued before the first seed read unwritten table entries and give
// undefined values.
`include "combined_lcg_shuffle_rng_unit_assert.svh"
module combined_lcg_shuffle_rng_unit #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  clsrng_pkg::op_type                    req_operation,
   input  logic signed [clsrng_pkg::SEED_W-1:0]  req_seed_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [clsrng_pkg::VAL_W-1:0]          rsp_random_value
);
   import clsrng_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int JW = $clog2(TABLE_DEPTH + 8);
   localparam int PW = VAL_W + IW + 1;
   localparam logic [VAL_W-1:0] NDIV =
      VAL_W'(1 + (64'(M1) - 64'd1) / TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DRAW_IDX,
      S_DRAW_OUT,
      S_SEED_MUL,
      S_SEED_RED
   } state_type;

   state_type        state_ff, state_in;
   logic [VAL_W-1:0] s1_ff, s1_in;
   logic [VAL_W-1:0] s2_ff, s2_in;
   logic [VAL_W-1:0] last_ff, last_in;
   logic [JW-1:0]    step_ff, step_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [IW-1:0]    est_ff;

   logic [VAL_W-1:0] red1, red2;
   logic [PW-1:0]    est_prod;
   logic [IW:0]      est_plus;
   logic [PW-1:0]    thr;
   logic [IW:0]      idx_wide;
   logic [IW-1:0]    idx_calc;
   logic [VAL_W-1:0] seed_start;
   logic [31:0]      diff;
   logic [31:0]      y_wide;
   logic             accept;
   logic             draw_done;

   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [VAL_W-1:0] wr_data;
   logic             rd_en;
   logic [VAL_W-1:0] rd_data;

   clsrng_mulmod u_gen1 (
      .clock      (clock),
      .operand    (s1_ff),
      .multiplier (A1),
      .fold       (C1),
      .modulus    (M1),
      .result     (red1)
   );

   clsrng_mulmod u_gen2 (
      .clock      (clock),
      .operand    (s2_ff),
      .multiplier (A2),
      .fold       (C2),
      .modulus    (M2),
      .result     (red2)
   );

   clsrng_ram #(
      .WIDTH (VAL_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_calc),
      .rd_data (rd_data)
   );

   assign est_prod = PW'(last_ff) * PW'(TABLE_DEPTH);

   always_ff @(posedge clock) begin
      est_ff <= est_prod[VAL_W +: IW];
   end

   assign est_plus = {1'b0, est_ff} + (IW+1)'(1);
   assign thr      = PW'(est_plus) * PW'(NDIV);
   assign idx_wide = (PW'(last_ff) >= thr) ? est_plus : {1'b0, est_ff};
   assign idx_calc = (idx_wide > (IW+1)'(TABLE_DEPTH - 1)) ?
                     IW'(TABLE_DEPTH - 1) : idx_wide[IW-1:0];

   always_comb begin
      priority if (req_seed_value[SEED_W-1]) begin
         seed_start = VAL_W'(1);
      end else if (req_seed_value[VAL_W-1:0] == {VAL_W{1'b1}}) begin
         seed_start = {VAL_W{1'b1}};
      end else begin
         seed_start = req_seed_value[VAL_W-1:0] + VAL_W'(1);
      end
   end

   assign diff   = {1'b0, rd_data} - {1'b0, s2_ff};
   assign y_wide = diff[31] ? diff + ({1'b0, M1} - 32'd1) : diff;

   assign accept    = req_valid && !req_stall;
   assign draw_done = (state_ff == S_DRAW_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      last_in      = last_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = s1_ff;
      rd_en        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_SEED) begin
                  s1_in    = seed_start;
                  s2_in    = seed_start;
                  step_in  = JW'(TABLE_DEPTH + 7);
                  state_in = S_SEED_MUL;
               end else begin
                  state_in = S_DRAW_IDX;
               end
            end
         end
         S_DRAW_IDX: begin
            s1_in    = red1;
            s2_in    = red2;
            rd_en    = 1'b1;
            idx_in   = idx_calc;
            state_in = S_DRAW_OUT;
         end
         S_DRAW_OUT: begin
            if (draw_done) begin
               wr_en        = 1'b1;
               last_in      = y_wide[VAL_W-1:0];
               rsp_valid_in = 1'b1;
               rsp_value_in = y_wide[VAL_W-1:0];
               state_in     = S_IDLE;
            end
         end
         S_SEED_MUL: begin
            state_in = S_SEED_RED;
         end
         S_SEED_RED: begin
            s1_in   = red1;
            wr_addr = step_ff[IW-1:0];
            wr_data = red1;
            wr_en   = (step_ff < JW'(TABLE_DEPTH));
            if (step_ff == '0) begin
               last_in  = red1;
               state_in = S_IDLE;
            end else begin
               step_in  = step_ff - JW'(1);
               state_in = S_SEED_MUL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         s1_ff        <= VAL_W'(1);
         s2_ff        <= VAL_W'(1);
         last_ff      <= '0;
         step_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_value_ff <= '0;
      end else begin
         state_ff     <= state_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         last_ff      <= last_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   `CLSRNG_ASSERT(a_no_rw_overlap, clock, reset, !(wr_en && rd_en))
   `CLSRNG_ASSERT_IMPL(a_rd_in_range, clock, reset, rd_en, idx_calc <= IW'(TABLE_DEPTH - 1))
   `CLSRNG_ASSERT_IMPL(a_out_range, clock, reset, rsp_valid_ff, rsp_value_ff <= OUT_MAX)
   `CLSRNG_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_DRAW_OUT)

endmodule

/* bench/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     DEPTH         = 32;
   localparam longint MOD1          = longint'(clsrng_pkg::M1);
   localparam longint MUL1          = longint'(clsrng_pkg::A1);
   localparam longint QUO1          = 53668;
   localparam longint REM1          = 12211;
   localparam longint MOD2          = longint'(clsrng_pkg::M2);
   localparam longint MUL2          = longint'(clsrng_pkg::A2);
   localparam longint QUO2          = 52774;
   localparam longint REM2          = 3791;
   localparam longint BUCKET        = 1 + (MOD1 - 1) / DEPTH;
   localparam longint SEED_CEIL     = 64'sd2147483647;
   localparam int     SHOW_LIMIT    = 10;
   localparam int     SETTLE_CYCLES = 2 * (DEPTH + 8) + 20;
   localparam int     HOLD_CYCLES   = 250;
   localparam int     SEED_PCT      = 8;

   typedef struct {
      clsrng_pkg::op_type        op;
      logic signed [31:0]        seed;
   } rng_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   clsrng_pkg::op_type req_operation = clsrng_pkg::OP_DRAW;
   logic signed [clsrng_pkg::SEED_W-1:0] req_seed_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [clsrng_pkg::VAL_W-1:0] rsp_random_value;

   rng_beat_type req_queue[$];
   logic [30:0]  expected_values[$];

   longint gen1 = 1;
   longint gen2 = 1;
   longint prev_out = 0;
   longint mix_table[DEPTH];

   int  send_idle_pct = 23;
   int  recv_idle_pct = 59;
   int  phase = 0;
   int  mismatch_count = 0;
   bit  req_fire = 1'b0;
   bit  rsp_hold = 1'b0;

   combined_lcg_shuffle_rng_unit #(.TABLE_DEPTH(DEPTH)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_seed_value   (req_seed_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint schrage_mul(longint x, longint a, longint q, longint r,
                                          longint m);
      longint k;
      longint v;
      k = x / q;
      v = a * (x - k * q) - k * r;
      if (v < 0) v += m;
      return v;
   endfunction

   task automatic predict_beat(rng_beat_type b);
      longint s;
      longint idx;
      longint y;
      if (b.op == clsrng_pkg::OP_SEED) begin
         s = longint'(b.seed);
         if (s < SEED_CEIL) s++;
         if (s < 1) s = 1;
         gen1 = s;
         gen2 = s;
         for (int j = DEPTH + 7; j >= 0; j--) begin
            gen1 = schrage_mul(gen1, MUL1, QUO1, REM1, MOD1);
            if (j < DEPTH) mix_table[j] = gen1;
         end
         prev_out = mix_table[0];
      end else begin
         gen1 = schrage_mul(gen1, MUL1, QUO1, REM1, MOD1);
         gen2 = schrage_mul(gen2, MUL2, QUO2, REM2, MOD2);
         idx = prev_out / BUCKET;
         if (idx < 0) idx = 0;
         if (idx > DEPTH - 1) idx = DEPTH - 1;
         y = mix_table[idx] - gen2;
         mix_table[idx] = gen1;
         if (y < 0) y += MOD1 - 1;
         prev_out = y;
         expected_values.push_back(y[30:0]);
      end
   endtask

   task automatic queue_beat(clsrng_pkg::op_type op, logic signed [31:0] seed);
      rng_beat_type b;
      b.op = op;
      b.seed = seed;
      req_queue.push_back(b);
   endtask

   task automatic queue_random(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < SEED_PCT) begin
            pick = $urandom_range(9);
            case (pick)
               0: queue_beat(clsrng_pkg::OP_SEED, 32'h7FFF_FFFF);
               1: queue_beat(clsrng_pkg::OP_SEED, 32'h8000_0000);
               2: queue_beat(clsrng_pkg::OP_SEED, 32'h0000_0000);
               3: queue_beat(clsrng_pkg::OP_SEED, 32'hFFFF_FFFF);
               default: queue_beat(clsrng_pkg::OP_SEED, $urandom);
            endcase
         end else begin
            queue_beat(clsrng_pkg::OP_DRAW, $urandom);
         end
      end
   endtask

   task automatic wait_drained();
      while (req_queue.size() != 0 || expected_values.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      logic [30:0] want;
      if (rsp_valid && !rsp_stall) begin
         if (expected_values.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT)
               $display("%0t: unexpected result beat, random_value=%0d", $realtime,
                        rsp_random_value);
         end else begin
            want = expected_values.pop_front();
            if (rsp_random_value !== want) begin
               mismatch_count++;
               if (mismatch_count <= SHOW_LIMIT)
                  $display("%0t: random_value mismatch, expected %0d, got %0d", $realtime,
                           want, rsp_random_value);
            end
         end
      end
      req_fire = req_valid && !req_stall;
      if (req_fire) predict_beat(req_queue.pop_front());
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid      <= 1'b1;
            req_operation  <= req_queue[0].op;
            req_seed_value <= req_queue[0].seed;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= rsp_hold || ($urandom_range(99) < recv_idle_pct);
   end

   // hold the result side off while the sender keeps offering beats
   initial begin
      wait (phase == 2);
      repeat (10) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("** combined_lcg_shuffle_rng_unit: FAILED **");
      $finish;
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) mix_table[i] = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      queue_beat(clsrng_pkg::OP_SEED, 32'h7FFF_FFFF);
      queue_beat(clsrng_pkg::OP_DRAW, 32'h0000_0000);
      queue_beat(clsrng_pkg::OP_DRAW, 32'hFFFF_FFFF);
      queue_beat(clsrng_pkg::OP_DRAW, 32'h8000_0000);
      queue_beat(clsrng_pkg::OP_SEED, 32'h8000_0000);
      queue_beat(clsrng_pkg::OP_DRAW, 32'h7FFF_FFFF);
      queue_beat(clsrng_pkg::OP_DRAW, 32'h0000_0000);
      queue_beat(clsrng_pkg::OP_SEED, 32'h0000_0000);
      queue_beat(clsrng_pkg::OP_DRAW, 32'h5555_5555);
      queue_beat(clsrng_pkg::OP_SEED, 32'hFFFF_FFFF);
      queue_beat(clsrng_pkg::OP_DRAW, 32'hAAAA_AAAA);
      queue_beat(clsrng_pkg::OP_SEED, 32'h0000_0001);
      queue_beat(clsrng_pkg::OP_DRAW, 32'h0000_0000);
      queue_beat(clsrng_pkg::OP_SEED, 32'h7FFF_FFFE);
      queue_beat(clsrng_pkg::OP_DRAW, 32'h0000_0000);
      queue_beat(clsrng_pkg::OP_DRAW, 32'h0000_0000);
      queue_beat(clsrng_pkg::OP_SEED, 32'h5555_5555);
      queue_beat(clsrng_pkg::OP_DRAW, 32'h0000_0000);
      queue_beat(clsrng_pkg::OP_SEED, 32'hAAAA_AAAA);
      queue_beat(clsrng_pkg::OP_DRAW, 32'hFFFF_FFFF);
      queue_random(160);
      wait_drained();

      phase = 1;
      send_idle_pct = 59;
      recv_idle_pct = 23;
      queue_random(160);
      wait_drained();

      phase = 2;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(180);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_values.size() == 0)
         $display("** combined_lcg_shuffle_rng_unit: PASSED **");
      else
         $display("** combined_lcg_shuffle_rng_unit: FAILED **");
      $finish;
   end

endmodule
